FILE: hdl/ptpn_pkg.sv
// ----------------------------------------------------------------------------
// ptpn_pkg
// Shared types, constants and the CORDIC arctangent table for the pilot PLL.
// ----------------------------------------------------------------------------
package ptpn_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W = $clog2(NSTEPS + 1);
    localparam int CW = 40;  // CORDIC datapath width

    localparam logic [CW-1:0] CORDIC_X0 = CW'(652032874);

    typedef enum logic [1:0] {
        REG_FREQ,
        REG_PROP,
        REG_INTEG,
        REG_MULT
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_VEC,
        MODE_ROT
    } cordic_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_VEC,
        ST_KI,
        ST_KP,
        ST_PHASE,
        ST_ROT_FB,
        ST_MULT,
        ST_ROT_OUT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_ctrl_t;

    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: hdl/pilot_tone_pll_nco.sv
// ----------------------------------------------------------------------------
// pilot_tone_pll_nco
// Pilot-tone PLL: CORDIC phase detector, PI loop filter and multiplied NCO.
// ----------------------------------------------------------------------------
// The single shared CORDIC runs three passes per sample (atan2, feedback cos/sin,
// output cos), and a new sample is taken only after the previous result has been
// loaded into the output register. A result stalled at the output holds ST_OUT.
// Reset (aresetn low, synchronous): loop state and registers return to
// defaults, feedback cosine 32767, nco_multiplier 1.
module pilot_tone_pll_nco (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_nco_out
);

    localparam int CW = ptpn_pkg::CW;

    logic [31:0] freq_step_reg;
    logic [23:0] prop_gain_reg, integ_gain_reg;
    logic [3:0]  nco_mult_reg;

    logic [31:0] integ_acc_reg, phase_est_reg, tone_phase_reg, arg_reg, err_reg;
    logic signed [15:0] fb_cos_reg, fb_sin_reg, out_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [56:0] prod_reg;
    logic               flip_reg, out_valid_reg;
    logic               out_load;
    ptpn_pkg::state_t   state_reg, state_next;

    ptpn_pkg::cordic_ctrl_t           cctrl;
    logic signed [CW-1:0]             cx_in, cy_in, cx_out, cy_out;
    logic [31:0]                      cz_in, cz_out;
    logic                             cdone;

    // APB
    assign pready = 1'b1;
    always_comb begin
        unique case (ptpn_pkg::reg_idx_t'(paddr[3:2]))
            ptpn_pkg::REG_FREQ:  prdata = freq_step_reg;
            ptpn_pkg::REG_PROP:  prdata = {8'd0, prop_gain_reg};
            ptpn_pkg::REG_INTEG: prdata = {8'd0, integ_gain_reg};
            ptpn_pkg::REG_MULT:  prdata = {28'd0, nco_mult_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_step_reg  <= '0;
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            nco_mult_reg   <= 4'd1;
        end else if (psel && penable && pwrite) begin
            unique case (ptpn_pkg::reg_idx_t'(paddr[3:2]))
                ptpn_pkg::REG_FREQ:  freq_step_reg  <= pwdata;
                ptpn_pkg::REG_PROP:  prop_gain_reg  <= pwdata[23:0];
                ptpn_pkg::REG_INTEG: integ_gain_reg <= pwdata[23:0];
                ptpn_pkg::REG_MULT:  nco_mult_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    ptpn_cordic u_cordic (
        .aclk, .aresetn,
        .ctrl(cctrl), .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
        .x_out(cx_out), .y_out(cy_out), .z_out(cz_out), .done(cdone)
    );

    // Q2.30 to Q1.15 with rounding and saturation
    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        begin
            r = (v + CW'(16384)) >>> 15;
            if (r > CW'(32767)) return 16'sd32767;
            else if (r < -CW'(32768)) return -16'sd32768;
            else return r[15:0];
        end
    endfunction

    logic signed [CW-1:0] rx, ry;
    logic [31:0] rot_phase, gain_term;
    logic        rot_flip;
    logic signed [56:0] rnd;

    always_comb begin
        // total phase lives in arg_reg; ST_ROT_FB leaves the multiplied phase there too
        rot_flip  = (arg_reg[31:30] == 2'b01 && arg_reg != 32'h4000_0000) ||
                    (arg_reg[31:30] == 2'b10 && arg_reg != 32'hC000_0000);
        rot_phase = rot_flip ? arg_reg - 32'h8000_0000 : arg_reg;
        rx = flip_reg ? -cx_out : cx_out;
        ry = flip_reg ? -cy_out : cy_out;
        rnd = (state_reg == ptpn_pkg::ST_KI) ? (57'sd1 <<< 31) : (57'sd1 <<< 21);
        gain_term = (state_reg == ptpn_pkg::ST_KI) ? 32'((prod_reg + rnd) >>> 32)
                                                   : 32'((prod_reg + rnd) >>> 22);
    end

    // load the output register once the previous result has left
    assign out_load = (state_reg == ptpn_pkg::ST_OUT) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        cctrl.start = 1'b0;
        cctrl.mode  = ptpn_pkg::MODE_VEC;
        cx_in = {{(CW-32){px_reg[31]}}, px_reg};
        cy_in = {{(CW-32){py_reg[31]}}, py_reg};
        cz_in = '0;
        if (px_reg < 0) begin
            cx_in = -{{(CW-32){px_reg[31]}}, px_reg};
            cy_in = -{{(CW-32){py_reg[31]}}, py_reg};
            cz_in = 32'h8000_0000;
        end
        unique case (state_reg)
            ptpn_pkg::ST_IDLE: if (s_valid) state_next = ptpn_pkg::ST_PROD;
            ptpn_pkg::ST_PROD: begin
                cctrl.start = 1'b1;
                state_next  = ptpn_pkg::ST_VEC;
            end
            ptpn_pkg::ST_VEC:  if (cdone) state_next = ptpn_pkg::ST_KI;
            ptpn_pkg::ST_KI:   state_next = ptpn_pkg::ST_KP;
            ptpn_pkg::ST_KP:   state_next = ptpn_pkg::ST_PHASE;
            ptpn_pkg::ST_PHASE: begin
                state_next = ptpn_pkg::ST_ROT_FB;
            end
            ptpn_pkg::ST_ROT_FB: if (cdone) state_next = ptpn_pkg::ST_MULT;
            ptpn_pkg::ST_MULT:   state_next = ptpn_pkg::ST_ROT_OUT;
            ptpn_pkg::ST_ROT_OUT: if (cdone) state_next = ptpn_pkg::ST_OUT;
            ptpn_pkg::ST_OUT:    if (out_load) state_next = ptpn_pkg::ST_IDLE;
            default:             state_next = ptpn_pkg::ST_IDLE;
        endcase
        if (state_reg == ptpn_pkg::ST_PHASE || state_reg == ptpn_pkg::ST_MULT) begin
            cctrl.start = 1'b1;
            cctrl.mode  = ptpn_pkg::MODE_ROT;
            cx_in = ptpn_pkg::CORDIC_X0;
            cy_in = '0;
            cz_in = rot_phase;
        end
    end

    assign s_ready = (state_reg == ptpn_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ptpn_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            integ_acc_reg  <= '0;
            phase_est_reg  <= '0;
            tone_phase_reg <= '0;
            fb_cos_reg     <= 16'sd32767;
            fb_sin_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_valid && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ptpn_pkg::ST_IDLE: if (s_valid && s_ready) begin
                    px_reg <= 32'(s_sample) * 32'(fb_cos_reg);
                    py_reg <= -(32'(s_sample) * 32'(fb_sin_reg));
                end
                ptpn_pkg::ST_VEC: if (cdone) begin
                    if (px_reg == 0 && py_reg == 0) begin
                        err_reg  <= '0;
                        prod_reg <= '0;
                    end else begin
                        err_reg  <= cz_out;
                        prod_reg <= 57'($signed(cz_out))
                                    * 57'($signed({1'b0, integ_gain_reg}));
                    end
                end
                ptpn_pkg::ST_KI: begin
                    integ_acc_reg <= integ_acc_reg + gain_term;
                    prod_reg <= 57'($signed(err_reg)) * 57'($signed({1'b0, prop_gain_reg}));
                end
                ptpn_pkg::ST_KP: begin
                    phase_est_reg  <= phase_est_reg + gain_term + integ_acc_reg;
                    tone_phase_reg <= tone_phase_reg + freq_step_reg;
                    arg_reg <= tone_phase_reg + freq_step_reg
                               + phase_est_reg + gain_term + integ_acc_reg;
                end
                ptpn_pkg::ST_PHASE: flip_reg <= rot_flip;
                ptpn_pkg::ST_ROT_FB: if (cdone) begin
                    fb_cos_reg <= to_q15(rx);
                    fb_sin_reg <= to_q15(ry);
                    arg_reg    <= 32'(arg_reg * nco_mult_reg);
                end
                ptpn_pkg::ST_MULT: flip_reg <= rot_flip;
                // CORDIC holds its last result until the next start
                ptpn_pkg::ST_OUT: if (out_load) out_reg <= to_q15(rx);
                default: ;
            endcase
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_nco_out = out_reg;

endmodule

FILE: hdl/ptpn_cordic.sv
// ----------------------------------------------------------------------------
// ptpn_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module ptpn_cordic (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ptpn_pkg::cordic_ctrl_t       ctrl,
    input  logic signed [ptpn_pkg::CW-1:0] x_in,
    input  logic signed [ptpn_pkg::CW-1:0] y_in,
    input  logic [31:0]                  z_in,
    output logic signed [ptpn_pkg::CW-1:0] x_out,
    output logic signed [ptpn_pkg::CW-1:0] y_out,
    output logic [31:0]                  z_out,
    output logic                         done
);

    logic signed [ptpn_pkg::CW-1:0] x_reg, y_reg;
    logic [31:0]                    z_reg;
    logic [ptpn_pkg::STEP_W-1:0]    step_reg;
    logic                           busy_reg, done_reg;
    ptpn_pkg::cordic_mode_t         mode_reg;
    logic signed [ptpn_pkg::CW-1:0] xs, ys;
    logic                           dir_pos;
    logic [31:0]                    ang;

    always_comb begin
        xs      = x_reg >>> step_reg;
        ys      = y_reg >>> step_reg;
        ang     = ptpn_pkg::atan_turns(5'(step_reg));
        dir_pos = (mode_reg == ptpn_pkg::MODE_VEC) ? (y_reg > 0) : !z_reg[31];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            mode_reg <= ptpn_pkg::MODE_VEC;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                x_reg    <= x_in;
                y_reg    <= y_in;
                z_reg    <= z_in;
                mode_reg <= ctrl.mode;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // vectoring drives y to zero, rotation drives z to zero
                if (mode_reg == ptpn_pkg::MODE_VEC) begin
                    if (dir_pos) begin
                        x_reg <= x_reg + ys; y_reg <= y_reg - xs; z_reg <= z_reg + ang;
                    end else begin
                        x_reg <= x_reg - ys; y_reg <= y_reg + xs; z_reg <= z_reg - ang;
                    end
                end else begin
                    if (dir_pos) begin
                        x_reg <= x_reg - ys; y_reg <= y_reg + xs; z_reg <= z_reg - ang;
                    end else begin
                        x_reg <= x_reg + ys; y_reg <= y_reg - xs; z_reg <= z_reg + ang;
                    end
                end
                if (step_reg == ptpn_pkg::STEP_W'(ptpn_pkg::NSTEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign done  = done_reg;

endmodule

FILE: test/pll_checker.sv
// ----------------------------------------------------------------------------
// pll_checker
// Watches the register port and both channels of the pilot-tone PLL. Computes
// the expected NCO output for every accepted sample and compares it with the
// results that the block returns.
// ----------------------------------------------------------------------------
module pll_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_sample,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_nco_out,
    output int                 fail_count,
    output int                 pending
);

    localparam int STEPS = (ptpn_pkg::CORDIC_STEPS < 24) ? ptpn_pkg::CORDIC_STEPS : 24;
    localparam longint ROT_X0 = 652032874;

    localparam logic [31:0] ANGLE_TBL [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    // register copies
    logic [31:0] freq_step;
    logic [23:0] prop_gain;
    logic [23:0] integ_gain;
    logic [3:0]  nco_mult;

    // loop state
    logic [31:0] integ_acc;
    logic [31:0] phase_est;
    logic [31:0] tone_phase;
    longint      fb_cos;
    longint      fb_sin;

    logic signed [15:0] nco_expected[$];

    function automatic longint to_int32(input logic [31:0] u);
        return longint'(signed'(u));
    endfunction

    // phase error in signed turns * 2^32
    function automatic longint phase_error(input longint y_in, input longint x_in);
        longint x, y, xs, ys;
        logic [31:0] ang;
        x = x_in;
        y = y_in;
        ang = 32'd0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                ang = ang + ANGLE_TBL[i];
            end else begin
                x = x - ys;
                y = y + xs;
                ang = ang - ANGLE_TBL[i];
            end
        end
        return to_int32(ang);
    endfunction

    function automatic longint round_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    task automatic rotate(input logic [31:0] ph, output longint c, output longint s);
        longint z, x, y, xs, ys;
        bit flip;
        z = to_int32(ph);
        x = ROT_X0;
        y = 0;
        flip = 0;
        if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
            z = to_int32(ph - 32'h8000_0000);
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ANGLE_TBL[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ANGLE_TBL[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = round_q15(x);
        s = round_q15(y);
    endtask

    // round half up of err*gain / 2^sh, kept to 32 bits
    function automatic logic [31:0] scale_error(input longint err, input longint gain,
                                                input int sh);
        longint p;
        p = err * gain + (longint'(1) <<< (sh - 1));
        return 32'(p >>> sh);
    endfunction

    task automatic track_sample(input logic signed [15:0] smp);
        longint err, c, s, oc, os, v;
        logic [31:0] arg;
        v = longint'(smp);
        err = phase_error(-v * fb_sin, v * fb_cos);
        integ_acc = integ_acc + scale_error(err, longint'(integ_gain), 32);
        phase_est = phase_est + scale_error(err, longint'(prop_gain), 22) + integ_acc;
        tone_phase = tone_phase + freq_step;
        arg = tone_phase + phase_est;
        rotate(arg, c, s);
        fb_cos = c;
        fb_sin = s;
        rotate(arg * {28'd0, nco_mult}, oc, os);
        nco_expected.insert(nco_expected.size(), 16'(oc));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            freq_step  = '0;
            prop_gain  = '0;
            integ_gain = '0;
            nco_mult   = 4'd1;
            integ_acc  = '0;
            phase_est  = '0;
            tone_phase = '0;
            fb_cos     = 32767;
            fb_sin     = 0;
            fail_count = 0;
            nco_expected.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (ptpn_pkg::reg_idx_t'(paddr[3:2]))
                    ptpn_pkg::REG_FREQ:  freq_step  = pwdata;
                    ptpn_pkg::REG_PROP:  prop_gain  = pwdata[23:0];
                    ptpn_pkg::REG_INTEG: integ_gain = pwdata[23:0];
                    ptpn_pkg::REG_MULT:  nco_mult   = pwdata[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                track_sample(s_sample);
            if (m_valid && m_ready) begin
                if (nco_expected.size() == 0) begin
                    $error("nco_out: unexpected transaction, actual %0d", m_nco_out);
                    fail_count++;
                end else begin
                    if (m_nco_out !== nco_expected[0]) begin
                        $error("nco_out: expected %0d, actual %0d",
                               nco_expected[0], m_nco_out);
                        fail_count++;
                    end
                    void'(nco_expected.pop_front());
                end
            end
        end
        pending = nco_expected.size();
    end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the pilot-tone PLL with directed and random samples, pure tones and
// noise, across register settings, with random gaps and output stalls. The
// checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY   = 3 * (ptpn_pkg::CORDIC_STEPS + 1) + 6;
    localparam int MAX_CYCLE = 2000000;
    localparam real TWO_PI   = 6.283185307179586;

    localparam logic [3:0] ADDR_FREQ  = 4'd0;
    localparam logic [3:0] ADDR_KP    = 4'd4;
    localparam logic [3:0] ADDR_KI    = 4'd8;
    localparam logic [3:0] ADDR_MULT  = 4'd12;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_sample;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_nco_out;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left;
    int hold_req = 0;

    pilot_tone_pll_nco uut (.*);

    pll_checker chk (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .s_valid, .s_ready, .s_sample, .m_valid, .m_ready, .m_nco_out,
        .fail_count, .pending
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // output stall pattern, plus one long hold-off on request
    initial begin
        int mode;
        int hold_seen;
        hold_seen = 0;
        m_ready = 1'b0;
        forever begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
            end
            mode = $urandom_range(0, 2);
            for (int i = 0; i < 64 && hold_req == hold_seen; i++) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 9) < 7);
                    default: m_ready <= ($urandom_range(0, 9) < 2);
                endcase
                @(posedge aclk);
            end
        end
    end

    task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic signed [15:0] v, input bit steady);
        int gap;
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (!steady && burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // hold the input until every result is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic program_loop(input logic [31:0] f, input logic [23:0] kp,
                                input logic [23:0] ki, input logic [3:0] mult);
        drain();
        reg_write(ADDR_FREQ, f);
        reg_write(ADDR_KP, {8'd0, kp});
        reg_write(ADDR_KI, {8'd0, ki});
        reg_write(ADDR_MULT, {28'd0, mult});
    endtask

    // tone near the nominal frequency with phase offset and noise
    task automatic send_tone(input int count, input logic [31:0] f, input bit steady);
        real ph, dph, amp;
        int  v, noise;
        ph  = $urandom_range(0, 999) / 1000.0;
        dph = (real'(f) + real'($urandom_range(0, 4000)) - 2000.0) / 4294967296.0;
        amp = real'($urandom_range(1000, 32767));
        noise = $urandom_range(0, 4) * 500;
        for (int i = 0; i < count; i++) begin
            v = $rtoi(amp * $cos(TWO_PI * ph));
            if (noise > 0)
                v = v + $urandom_range(0, 2 * noise) - noise;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_sample(16'(v), steady);
            ph = ph + dph;
            ph = ph - $floor(ph);
        end
    endtask

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_sample(16'($urandom_range(0, 65535)), 0);
    endtask

    initial begin
        logic [31:0] f;
        burst_left = 5;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_sample = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, extreme samples, zero products
        send_sample(16'sh7fff, 0);
        send_sample(-16'sh8000, 0);
        send_sample(16'sh0000, 0);
        send_sample(16'sh0001, 0);
        send_sample(-16'sh0001, 0);

        // half-turn steps drive the feedback cosine negative
        program_loop(32'h8000_0000, 24'hff_ffff, 24'hff_ffff, 4'd0);
        send_sample(16'sh7fff, 0);
        send_sample(-16'sh8000, 0);
        send_sample(16'sh0000, 0);
        send_sample(16'sh4000, 0);

        program_loop(32'hffff_ffff, 24'h00_0000, 24'hff_ffff, 4'd15);
        send_sample(-16'sh8000, 0);
        send_sample(16'sh7fff, 0);
        send_sample(16'sh5555, 0);
        send_sample(-16'sh2aab, 0);

        program_loop(32'h0000_0000, 24'hff_ffff, 24'h00_0000, 4'd8);
        send_sample(16'sh7fff, 0);
        send_sample(16'sh0000, 0);
        send_sample(-16'sh8000, 0);

        program_loop(32'h4000_0000, 24'h00_1234, 24'h00_0042, 4'd1);
        send_sample(16'sh7fff, 0);
        send_sample(16'sh0000, 0);
        send_sample(-16'sh8000, 0);

        // random phases, mostly tones at plausible loop gains
        for (int p = 0; p < 16; p++) begin
            f = (p % 4 == 0) ? $urandom() : $urandom_range(0, 32'h1000_0000);
            if (p % 3 == 0)
                program_loop(f, 24'($urandom()), 24'($urandom()),
                             4'($urandom_range(0, 15)));
            else
                program_loop(f, 24'($urandom_range(0, 24'h08_0000)),
                             24'($urandom_range(0, 24'h00_4000)),
                             4'($urandom_range(1, 8)));
            if (p == 5) begin
                // long output hold-off while input keeps coming
                hold_req++;
                send_tone(20, f, 1);
            end
            send_tone(75, f, 0);
            send_noise(32);
        end

        drain();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
